FILE: design/sfha_pkg.sv
// sfha_pkg: shared types and constants for the segregated fit heap allocator
// controller states, datapath commands, status codes and size class lookup
// no dependencies
package sfha_pkg;

    localparam int CLASS_COUNT   = 14;
    localparam int BOUND_COUNT   = 13;
    localparam int FIRST_PAYLOAD = 128;
    localparam int INIT_BREAK    = 592;
    localparam int INIT_CLASS    = 5;
    localparam int MIN_BLOCK     = 16;

    // word indexes of the initial layout
    localparam int PRO_HDR_W  = 29;
    localparam int PRO_FTR_W  = 30;
    localparam int FREE_HDR_W = 31;
    localparam int FREE_FTR_W = 146;
    localparam int EPI_HDR_W  = 147;
    localparam logic [31:0] PRO_TAG  = 32'd9;
    localparam logic [31:0] FREE_HDR = 32'd466;
    localparam logic [31:0] FREE_FTR = 32'd464;
    localparam logic [31:0] EPI_TAG  = 32'd1;

    localparam logic [31:0] CLASS_BOUND [BOUND_COUNT] = '{
        32'd16, 32'd32, 32'd64, 32'd128, 32'd256, 32'd480, 32'd960, 32'd1920,
        32'd3840, 32'd7680, 32'd15360, 32'd30720, 32'd61440
    };

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_OOM     = 2'd2,
        ST_BADFREE = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        U_NOP, U_CLR, U_LOAD, U_SINIT, U_SHEAD, U_SCHK, U_SLINK, U_SNEXT,
        U_GROW0, U_GROW1, U_GROW2, U_GROW3,
        U_M0, U_M1, U_M2, U_M3, U_M4, U_M4B, U_M5, U_M6, U_M7, U_M8, U_M9,
        U_C0, U_C1, U_C2, U_C3, U_C4, U_C5, U_C6,
        U_FCHK, U_FWALK, U_FHDR, U_FR0, U_FR1, U_FR2, U_FR3,
        U_UL0, U_UL1, U_UL2, U_UL3, U_UL4,
        U_PS0, U_PS1, U_PS2, U_PS3,
        U_OUT
    } t_uop;

    typedef enum logic [5:0] {
        S_CLR, S_IDLE, S_DISP, S_SINIT, S_SHEAD, S_SCHK, S_SLINK, S_SNEXT,
        S_GROW0, S_GROW1, S_GROW2, S_GROW3, S_GROW4,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M4B, S_M5, S_M6, S_M7, S_M8, S_M9, S_MDONE,
        S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6,
        S_FCHK, S_FWALK, S_FHDR, S_FR0, S_FR1, S_FR2, S_FR3, S_FR4,
        S_UL0, S_UL1, S_UL2, S_UL3, S_UL4,
        S_PS0, S_PS1, S_PS2, S_PS3,
        S_DONE
    } t_state;

    typedef struct packed {
        t_uop    uop;
        t_status code;
    } t_ctl;

    typedef struct packed {
        logic clr_last;
        logic op_free;
        logic req_zero;
        logic head_zero;
        logic fit_hit;
        logic link_zero;
        logic best_nz;
        logic last_class;
        logic grow_fail;
        logic pa;
        logic na_now;
        logic na;
        logic split;
        logic faddr_ok;
        logic walk_go;
        logic hdr_zero;
        logic walk_hit;
        logic hdr_alloc;
        logic out_busy;
    } t_stat;

    function automatic logic [3:0] class_of(input logic [31:0] s);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < BOUND_COUNT; i++) begin
            if (s >= CLASS_BOUND[i]) c = 4'(i + 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] init_word(input logic [31:0] idx);
        logic [31:0] v;
        case (idx)
            32'(PRO_HDR_W):  v = PRO_TAG;
            32'(PRO_FTR_W):  v = PRO_TAG;
            32'(FREE_HDR_W): v = FREE_HDR;
            32'(FREE_FTR_W): v = FREE_FTR;
            32'(EPI_HDR_W):  v = EPI_TAG;
            default:         v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/sfha_ctrl.sv
// sfha_ctrl: sequencing state machine of the allocator
// drives one datapath command per cycle from the status flags; uses sfha_pkg
module sfha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sfha_pkg::t_stat i_stat,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output sfha_pkg::t_ctl o_ctl
);
    import sfha_pkg::*;

    t_state  r_state, n_state;
    t_state  r_ret, n_ret;
    t_state  r_mret, n_mret;
    t_status r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret   <= S_IDLE;
            r_mret  <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_mret  <= n_mret;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_mret     = r_mret;
        n_code     = r_code;
        o_ctl.uop  = U_NOP;
        o_ctl.code = r_code;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_ctl.uop = U_CLR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_ctl.uop = U_LOAD;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.op_free) begin
                    n_state = S_FCHK;
                end else if (i_stat.req_zero) begin
                    n_code  = ST_ZERO;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SINIT;
                end
            end
            S_SINIT: begin
                o_ctl.uop = U_SINIT;
                n_state   = S_SHEAD;
            end
            S_SHEAD: begin
                o_ctl.uop = U_SHEAD;
                n_state   = i_stat.head_zero ? S_SNEXT : S_SCHK;
            end
            S_SCHK: begin
                o_ctl.uop = U_SCHK;
                n_state   = i_stat.fit_hit ? S_C0 : S_SLINK;
            end
            S_SLINK: begin
                o_ctl.uop = U_SLINK;
                if (!i_stat.link_zero) n_state = S_SCHK;
                else if (i_stat.best_nz) n_state = S_C0;
                else n_state = S_SNEXT;
            end
            S_SNEXT: begin
                o_ctl.uop = U_SNEXT;
                n_state   = i_stat.last_class ? S_GROW0 : S_SHEAD;
            end
            S_GROW0: begin
                o_ctl.uop = U_GROW0;
                if (i_stat.grow_fail) begin
                    n_code  = ST_OOM;
                    n_state = S_DONE;
                end else begin
                    n_state = S_GROW1;
                end
            end
            S_GROW1: begin
                o_ctl.uop = U_GROW1;
                n_state   = S_GROW2;
            end
            S_GROW2: begin
                o_ctl.uop = U_GROW2;
                n_state   = S_GROW3;
            end
            S_GROW3: begin
                o_ctl.uop = U_GROW3;
                n_ret     = S_GROW4;
                n_state   = S_PS0;
            end
            S_GROW4: begin
                n_mret  = S_C0;
                n_state = S_M0;
            end
            S_M0: begin
                o_ctl.uop = U_M0;
                n_state   = S_M1;
            end
            S_M1: begin
                o_ctl.uop = U_M1;
                n_state   = S_M2;
            end
            S_M2: begin
                o_ctl.uop = U_M2;
                if (i_stat.pa && i_stat.na_now) begin
                    n_state = r_mret;
                end else begin
                    n_ret   = S_M3;
                    n_state = S_UL0;
                end
            end
            S_M3: begin
                o_ctl.uop = U_M3;
                if (i_stat.pa) begin
                    n_ret   = S_M4;
                    n_state = S_UL0;
                end else begin
                    n_state = S_M5;
                end
            end
            S_M4: begin
                o_ctl.uop = U_M4;
                n_state   = S_M4B;
            end
            S_M4B: begin
                o_ctl.uop = U_M4B;
                n_ret     = S_MDONE;
                n_state   = S_PS0;
            end
            S_M5: begin
                o_ctl.uop = U_M5;
                n_ret     = S_M6;
                n_state   = S_UL0;
            end
            S_M6: begin
                o_ctl.uop = U_M6;
                n_state   = S_M7;
            end
            S_M7: begin
                o_ctl.uop = U_M7;
                if (!i_stat.na) begin
                    n_ret   = S_M8;
                    n_state = S_UL0;
                end else begin
                    n_state = S_M8;
                end
            end
            S_M8: begin
                o_ctl.uop = U_M8;
                n_state   = S_M9;
            end
            S_M9: begin
                o_ctl.uop = U_M9;
                n_ret     = S_MDONE;
                n_state   = S_PS0;
            end
            S_MDONE: n_state = r_mret;
            S_C0: begin
                o_ctl.uop = U_C0;
                n_code    = ST_OK;
                n_state   = S_C1;
            end
            S_C1: begin
                o_ctl.uop = U_C1;
                n_ret     = S_C2;
                n_state   = S_UL0;
            end
            S_C2: begin
                o_ctl.uop = U_C2;
                n_state   = i_stat.split ? S_C3 : S_C5;
            end
            S_C3: begin
                o_ctl.uop = U_C3;
                n_state   = S_C4;
            end
            S_C4: begin
                o_ctl.uop = U_C4;
                n_ret     = S_DONE;
                n_state   = S_PS0;
            end
            S_C5: begin
                o_ctl.uop = U_C5;
                n_state   = S_C6;
            end
            S_C6: begin
                o_ctl.uop = U_C6;
                n_state   = S_DONE;
            end
            S_FCHK: begin
                o_ctl.uop = U_FCHK;
                n_code    = ST_BADFREE;
                n_state   = i_stat.faddr_ok ? S_FWALK : S_DONE;
            end
            S_FWALK: begin
                o_ctl.uop = U_FWALK;
                n_state   = i_stat.walk_go ? S_FHDR : S_DONE;
            end
            S_FHDR: begin
                o_ctl.uop = U_FHDR;
                if (i_stat.hdr_zero) n_state = S_DONE;
                else if (i_stat.walk_hit) n_state = i_stat.hdr_alloc ? S_FR0 : S_DONE;
                else n_state = S_FWALK;
            end
            S_FR0: begin
                o_ctl.uop = U_FR0;
                n_state   = S_FR1;
            end
            S_FR1: begin
                o_ctl.uop = U_FR1;
                n_state   = S_FR2;
            end
            S_FR2: begin
                o_ctl.uop = U_FR2;
                n_state   = S_FR3;
            end
            S_FR3: begin
                o_ctl.uop = U_FR3;
                n_ret     = S_FR4;
                n_state   = S_PS0;
            end
            S_FR4: begin
                n_code  = ST_OK;
                n_mret  = S_DONE;
                n_state = S_M0;
            end
            S_UL0: begin
                o_ctl.uop = U_UL0;
                n_state   = S_UL1;
            end
            S_UL1: begin
                o_ctl.uop = U_UL1;
                n_state   = S_UL2;
            end
            S_UL2: begin
                o_ctl.uop = U_UL2;
                n_state   = S_UL3;
            end
            S_UL3: begin
                o_ctl.uop = U_UL3;
                n_state   = S_UL4;
            end
            S_UL4: begin
                o_ctl.uop = U_UL4;
                n_state   = r_ret;
            end
            S_PS0: begin
                o_ctl.uop = U_PS0;
                n_state   = S_PS1;
            end
            S_PS1: begin
                o_ctl.uop = U_PS1;
                n_state   = S_PS2;
            end
            S_PS2: begin
                o_ctl.uop = U_PS2;
                n_state   = S_PS3;
            end
            S_PS3: begin
                o_ctl.uop = U_PS3;
                n_state   = r_ret;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_ctl.uop = U_OUT;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: design/sfha_dpath.sv
// sfha_dpath: heap word memory, class list heads, working registers, result register
// executes one command from sfha_ctrl per cycle; uses sfha_pkg
module sfha_dpath #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sfha_pkg::t_ctl  i_ctl,
    output sfha_pkg::t_stat o_stat,
    input  logic            i_op,
    input  logic [15:0]     i_req,
    input  logic [15:0]     i_addr,
    input  logic [16:0]     i_fit,
    input  logic [16:0]     i_ext,
    input  logic            i_m_tready,
    output logic            o_m_tvalid,
    output logic [15:0]     o_payload_addr,
    output logic [1:0]      o_status
);
    import sfha_pkg::*;

    localparam int HEAP_WORDS = HEAP_BYTES / 4;
    localparam int WI = $clog2(HEAP_WORDS);
    localparam int HB = $clog2(HEAP_BYTES);
    localparam int AW = ((HB > 17) ? HB : 17) + 2;
    localparam logic [AW-1:0] SZ_MASK = ~AW'(7);
    localparam logic [AW-1:0] HEAP_TOP = AW'(HEAP_BYTES);

    logic [31:0]   r_mem [HEAP_WORDS];
    logic [31:0]   r_rdata;
    logic [AW-1:0] r_heads [CLASS_COUNT];

    logic [WI-1:0] r_clr;
    logic          r_op;
    logic [15:0]   r_req, r_addr;
    logic [AW-1:0] r_asize, r_break, r_p, r_u, r_size, r_nsz, r_nxt, r_prv;
    logic [AW-1:0] r_best, r_best_sz, r_uprv, r_unxt, r_first, r_w;
    logic [3:0]    r_c, r_ucls;
    logic          r_pa, r_na, r_ppa;
    logic          r_oval;
    logic [15:0]   r_oaddr;
    logic [1:0]    r_ostat;

    logic [AW-1:0] raddr, waddr;
    logic [31:0]   wdata;
    logic          we;
    logic [AW-1:0] w_rsz, w_rlink, w_head, w_pfirst, w_addr, w_gbytes, w_gwords, w_gsize;
    logic [AW-1:0] w_fit, w_ext, w_rem;
    logic [3:0]    w_pcls;
    logic          w_ff, w_rin, w_win;
    logic [31:0]   w_pa32;

    assign w_rsz    = r_rdata[AW-1:0] & SZ_MASK;
    assign w_rlink  = r_rdata[AW-1:0];
    assign w_head   = r_heads[r_c];
    assign w_pcls   = class_of(32'(w_rsz));
    assign w_pfirst = r_heads[w_pcls];
    assign w_addr   = AW'(r_addr);
    assign w_fit    = AW'(i_fit);
    assign w_ext    = AW'(i_ext);
    assign w_ff     = r_asize < w_fit;
    assign w_gbytes = (r_asize > w_ext) ? r_asize : w_ext;
    assign w_gwords = w_gbytes >> 2;
    assign w_gsize  = (w_gwords + AW'(w_gwords[0])) << 2;
    assign w_rem    = r_size - r_asize;
    assign w_pa32   = {30'b0, r_pa, 1'b0};
    assign w_rin    = raddr[AW-1:2] < (AW-2)'(HEAP_WORDS);
    assign w_win    = waddr[AW-1:2] < (AW-2)'(HEAP_WORDS);

    always_comb begin
        raddr = '0;
        waddr = '0;
        wdata = '0;
        we    = 1'b0;
        case (i_ctl.uop)
            U_CLR: begin
                we    = 1'b1;
                waddr = AW'({r_clr, 2'b00});
                wdata = init_word(32'(r_clr));
            end
            U_SHEAD: raddr = w_head - AW'(4);
            U_SCHK:  raddr = r_p + AW'(4);
            U_SLINK: raddr = w_rlink - AW'(4);
            U_GROW0: raddr = r_break - AW'(4);
            U_GROW1: begin
                we    = 1'b1;
                waddr = r_p - AW'(4);
                wdata = 32'(r_size) | (r_rdata & 32'd2);
            end
            U_GROW2: begin
                we    = 1'b1;
                waddr = r_p + r_size - AW'(8);
                wdata = 32'(r_size);
            end
            U_GROW3: begin
                we    = 1'b1;
                waddr = r_p + r_size - AW'(4);
                wdata = 32'd1;
            end
            U_M0: raddr = r_p - AW'(4);
            U_M1: raddr = r_p + w_rsz - AW'(4);
            U_M3: raddr = r_p - AW'(8);
            U_M4: begin
                we    = 1'b1;
                waddr = r_p - AW'(4);
                wdata = 32'(r_size + r_nsz) | 32'd2;
            end
            U_M4B: begin
                we    = 1'b1;
                waddr = r_p + r_size - AW'(8);
                wdata = 32'(r_size);
            end
            U_M6: raddr = r_prv - AW'(4);
            U_M8: begin
                we    = 1'b1;
                waddr = r_prv - AW'(4);
                wdata = 32'(r_size) | {30'b0, r_ppa, 1'b0};
            end
            U_M9: begin
                we    = 1'b1;
                waddr = r_prv + r_size - AW'(8);
                wdata = 32'(r_size);
            end
            U_C0: raddr = r_p - AW'(4);
            U_C2: begin
                we    = 1'b1;
                waddr = r_p - AW'(4);
                wdata = ((r_size >= r_asize + AW'(MIN_BLOCK)) ? 32'(r_asize) : 32'(r_size))
                        | w_pa32 | 32'd1;
            end
            U_C3: begin
                we    = 1'b1;
                waddr = r_p + r_asize - AW'(4);
                wdata = 32'(w_rem) | 32'd2;
            end
            U_C4: begin
                we    = 1'b1;
                waddr = r_p + r_size - AW'(8);
                wdata = 32'(w_rem);
            end
            U_C5: raddr = r_p + r_size - AW'(4);
            U_C6: begin
                we    = 1'b1;
                waddr = r_p + r_size - AW'(4);
                wdata = r_rdata | 32'd2;
            end
            U_FWALK: raddr = r_w - AW'(4);
            U_FR0: begin
                we    = 1'b1;
                waddr = r_p - AW'(4);
                wdata = 32'(r_size) | w_pa32;
            end
            U_FR1: begin
                we    = 1'b1;
                waddr = r_p + r_size - AW'(8);
                wdata = 32'(r_size);
            end
            U_FR2: raddr = r_p + r_size - AW'(4);
            U_FR3: begin
                we    = 1'b1;
                waddr = r_p + r_size - AW'(4);
                wdata = r_rdata & ~32'd2;
            end
            U_UL0: raddr = r_u - AW'(4);
            U_UL1: raddr = r_u;
            U_UL2: raddr = r_u + AW'(4);
            U_UL3: begin
                we    = (r_uprv != '0);
                waddr = r_uprv + AW'(4);
                wdata = 32'(w_rlink);
            end
            U_UL4: begin
                we    = (r_unxt != '0);
                waddr = r_unxt;
                wdata = 32'(r_uprv);
            end
            U_PS0: raddr = r_u - AW'(4);
            U_PS1: begin
                we    = 1'b1;
                waddr = r_u;
                wdata = '0;
            end
            U_PS2: begin
                we    = 1'b1;
                waddr = r_u + AW'(4);
                wdata = 32'(r_first);
            end
            U_PS3: begin
                we    = (r_first != '0);
                waddr = r_first;
                wdata = 32'(r_u);
            end
            default: we = 1'b0;
        endcase
    end

    // heap word memory, registered read
    always_ff @(posedge i_clk) begin
        if (we && w_win) r_mem[waddr[WI+1:2]] <= wdata;
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= w_rin ? r_mem[raddr[WI+1:2]] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_break <= AW'(INIT_BREAK);
            r_oval  <= 1'b0;
            for (int i = 0; i < CLASS_COUNT; i++) begin
                r_heads[i] <= (i == INIT_CLASS) ? AW'(FIRST_PAYLOAD) : '0;
            end
        end else begin
            if (i_ctl.uop == U_OUT) r_oval <= 1'b1;
            else if (i_m_tready) r_oval <= 1'b0;
            case (i_ctl.uop)
                U_CLR:   r_clr <= r_clr + WI'(1);
                U_GROW3: r_break <= r_break + r_size;
                U_UL3:   if (r_uprv == '0) r_heads[r_ucls] <= w_rlink;
                U_PS2:   r_heads[r_ucls] <= r_u;
                default: r_clr <= r_clr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.uop)
            U_LOAD: begin
                r_op    <= i_op;
                r_req   <= i_req;
                r_addr  <= i_addr;
                r_asize <= (i_req <= 16'd8) ? AW'(MIN_BLOCK)
                           : ((AW'(i_req) + AW'(11)) & SZ_MASK);
            end
            U_SINIT: r_c <= class_of(32'(r_asize));
            U_SHEAD: begin
                r_p       <= w_head;
                r_best    <= '0;
                r_best_sz <= '0;
            end
            U_SCHK: begin
                if (!w_ff && r_asize < w_rsz && (r_best == '0 || w_rsz < r_best_sz)) begin
                    r_best    <= r_p;
                    r_best_sz <= w_rsz;
                end
            end
            U_SLINK: r_p <= (w_rlink == '0) ? r_best : w_rlink;
            U_SNEXT: r_c <= r_c + 4'd1;
            U_GROW0: begin
                r_size <= w_gsize;
                r_p    <= r_break;
            end
            U_GROW3: r_u <= r_p;
            U_M1: begin
                r_size <= w_rsz;
                r_pa   <= r_rdata[1];
                r_nxt  <= r_p + w_rsz;
            end
            U_M2: begin
                r_na  <= r_rdata[0];
                r_nsz <= w_rsz;
                r_u   <= r_p;
            end
            U_M3: if (r_pa) r_u <= r_nxt;
            U_M4: r_size <= r_size + r_nsz;
            U_M4B: r_u <= r_p;
            U_M5: begin
                r_prv <= r_p - w_rsz;
                r_u   <= r_p - w_rsz;
            end
            U_M7: begin
                r_ppa  <= r_rdata[1];
                r_size <= r_size + w_rsz + (r_na ? '0 : r_nsz);
                if (!r_na) r_u <= r_nxt;
            end
            U_M9: begin
                r_p <= r_prv;
                r_u <= r_prv;
            end
            U_C1: begin
                r_size <= w_rsz;
                r_pa   <= r_rdata[1];
                r_u    <= r_p;
            end
            U_C4: r_u <= r_p + r_asize;
            U_FCHK: r_w <= AW'(FIRST_PAYLOAD);
            U_FHDR: begin
                r_w    <= r_w + w_rsz;
                r_size <= w_rsz;
                r_pa   <= r_rdata[1];
                r_p    <= w_addr;
            end
            U_FR3: r_u <= r_p;
            U_UL1: r_ucls <= w_pcls;
            U_UL2: r_uprv <= w_rlink;
            U_UL3: r_unxt <= w_rlink;
            U_PS1: begin
                r_ucls  <= w_pcls;
                r_first <= w_pfirst;
            end
            U_OUT: begin
                r_oaddr <= (i_ctl.code == ST_OK && !r_op) ? r_p[15:0] : '0;
                r_ostat <= i_ctl.code;
            end
            default: r_ucls <= r_ucls;
        endcase
    end

    always_comb begin
        o_stat.clr_last   = (r_clr == WI'(HEAP_WORDS - 1));
        o_stat.op_free    = r_op;
        o_stat.req_zero   = (r_req == '0);
        o_stat.head_zero  = (w_head == '0);
        o_stat.fit_hit    = w_ff ? (r_asize <= w_rsz) : (w_rsz == r_asize);
        o_stat.link_zero  = (w_rlink == '0);
        o_stat.best_nz    = (r_best != '0);
        o_stat.last_class = (r_c == 4'(CLASS_COUNT - 1));
        o_stat.grow_fail  = (w_gsize < AW'(MIN_BLOCK)) || (r_break + w_gsize > HEAP_TOP);
        o_stat.pa         = r_pa;
        o_stat.na_now     = r_rdata[0];
        o_stat.na         = r_na;
        o_stat.split      = (r_size >= r_asize + AW'(MIN_BLOCK));
        o_stat.faddr_ok   = (r_addr[2:0] == 3'b000) && (w_addr >= AW'(FIRST_PAYLOAD))
                            && (w_addr < r_break);
        o_stat.walk_go    = (r_w < r_break) && (r_w <= w_addr);
        o_stat.hdr_zero   = (w_rsz == '0);
        o_stat.walk_hit   = (r_w == w_addr);
        o_stat.hdr_alloc  = r_rdata[0];
        o_stat.out_busy   = r_oval && !i_m_tready;
    end

    assign o_m_tvalid     = r_oval;
    assign o_payload_addr = r_oaddr;
    assign o_status       = r_ostat;

endmodule

FILE: design/segregated_fit_heap_allocator.sv
// Segregated fit heap allocator with boundary tags over a single-port word memory of
// HEAP_BYTES bytes. After reset a sweep writes the initial heap layout into every word
// and no request is taken until it ends; configuration writes are taken at any
// time. One request at a time: an allocate searches the size classes and visits their
// free-list nodes, plus growth, splitting and list updates as needed; a free walks the
// blocks from the heap start, then does tagging and coalescing, unless the address is
// rejected at once. The single memory port reads or writes one tag word per cycle.
// A finished result waits in an output register while the next request is taken.
module segregated_fit_heap_allocator #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // req_size [15:0], block_addr [31:16]
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // payload_addr [15:0]
    output logic [1:0]  m_axis_tuser,   // status [1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sfha_pkg::*;

    localparam logic CFG_FIT = 1'b0;
    localparam logic CFG_EXT = 1'b1;

    logic [16:0] r_fit, r_ext;
    t_ctl        w_ctl;
    t_stat       w_stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit <= 17'd960;
            r_ext <= 17'd464;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                CFG_FIT: r_fit <= pwdata[16:0];
                CFG_EXT: r_ext <= pwdata[16:0];
                default: r_fit <= r_fit;
            endcase
        end
    end

    assign prdata = (paddr[2] == CFG_EXT) ? {15'b0, r_ext} : {15'b0, r_fit};

    sfha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (w_stat),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_ctl      (w_ctl)
    );

    sfha_dpath #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .o_stat         (w_stat),
        .i_op           (s_axis_tuser),
        .i_req          (s_axis_tdata[15:0]),
        .i_addr         (s_axis_tdata[31:16]),
        .i_fit          (r_fit),
        .i_ext          (r_ext),
        .i_m_tready     (m_axis_tready),
        .o_m_tvalid     (m_axis_tvalid),
        .o_payload_addr (m_axis_tdata),
        .o_status       (m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.uop == U_OUT |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("result loaded over a pending result");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while one is in progress");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_ctl.uop == U_OUT))
        else $error("result valid without a load");
`endif

endmodule
